@@ rtl/rjmd_pkg.sv @@
//------------------------------------------------------------------------------
// rjmd_pkg
// types, constants and sizes shared by the rssi jitter motion detector
//------------------------------------------------------------------------------
`default_nettype none
package rjmd_pkg;
    localparam int unsigned RING_DEPTH_DEF = 48;
    localparam logic [15:0] WINDOW_RST = 16'd3500;
    localparam logic [15:0] CAL_RST    = 16'd12000;
    localparam logic [15:0] HOLD_RST   = 16'd4500;
    localparam logic [6:0]  THR_RST    = 7'd5;
    localparam int unsigned QDEPTH     = 2;

    typedef enum logic [1:0] {
        K_FRAME = 2'd0,
        K_TICK  = 2'd1,
        K_RECAL = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        R_WINDOW = 2'd0,
        R_CAL    = 2'd1,
        R_HOLD   = 2'd2,
        R_THR    = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rssi_value;
        logic       frame_is_data;
        logic       frame_clean;
    } t_in_word;

    typedef struct packed {
        logic        motion;
        logic        report_valid;
        logic        report_value;
        logic [14:0] deviation_q8;
        logic        calibrated;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic       push;
        logic       tick;
        logic       recal;
        logic [7:0] sample;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_UPD, S_MUL1, S_MUL2, S_DIFF, S_DIV, S_SQRT,
        S_DEC, S_OUT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/rjmd_if.sv @@
//------------------------------------------------------------------------------
// rjmd_if
// valid/ready channel carrying one word of type T
//------------------------------------------------------------------------------
`default_nettype none
interface rjmd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rjmd_cfg_if.sv @@
//------------------------------------------------------------------------------
// rjmd_cfg_if
// register write channel: index and data
//------------------------------------------------------------------------------
`default_nettype none
interface rjmd_cfg_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rjmd_front.sv @@
//------------------------------------------------------------------------------
// rjmd_front
// classifies input words and queues commands for the back end
//------------------------------------------------------------------------------
`default_nettype none
module rjmd_front (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rjmd_if.sink s_in,
    output rjmd_pkg::t_cmd o_cmd,
    output logic o_cmd_valid,
    input  wire  i_cmd_pop
);
    import rjmd_pkg::*;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       w_push, w_pop;

    assign s_in.ready  = (r_cnt != 2'(QDEPTH));
    assign w_push      = s_in.valid && s_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cmd.push   = (s_in.data.kind == K_FRAME) && s_in.data.frame_is_data
                       && s_in.data.frame_clean;
        n_cmd.tick   = (s_in.data.kind == K_TICK);
        n_cmd.recal  = (s_in.data.kind == K_RECAL);
        n_cmd.sample = s_in.data.rssi_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/rjmd_back.sv @@
//------------------------------------------------------------------------------
// rjmd_back
// ring, running sums, deviation (divide + square root) and motion decision
//------------------------------------------------------------------------------
`default_nettype none
module rjmd_back #(
    parameter int unsigned RING_DEPTH = rjmd_pkg::RING_DEPTH_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  rjmd_pkg::t_cmd i_cmd,
    input  wire  i_cmd_valid,
    output logic o_cmd_pop,
    input  wire  [15:0] i_window_ms,
    input  wire  [15:0] i_cal_ms,
    input  wire  [15:0] i_hold_ms,
    input  wire  [6:0]  i_thr,
    rjmd_if.source m_out
);
    import rjmd_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = 8 + CW;
    localparam int QW = 16 + CW + 2;
    localparam int DW = 2 * SW + 2;
    localparam int NW = DW + 16;
    localparam int MW = 2 * CW;
    localparam int RW = NW / 2 + 1;
    localparam logic [CW-1:0] HALF = CW'(RING_DEPTH / 2);
    localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

    logic [7:0]  r_ring [RING_DEPTH];
    logic [7:0]  r_old;
    t_state      r_st, n_st;
    t_cmd        r_cmd;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_wi;
    logic signed [SW-1:0] r_sum;
    logic signed [QW-1:0] r_sq;
    logic [14:0] r_dev, r_floor;
    logic [15:0] r_win, r_cal_el, r_hold_left;
    logic        r_cal_st, r_cal_done, r_motion, r_hl;
    logic [1:0]  r_last;
    logic        r_rv, r_rval;
    logic [DW-1:0] r_p1, r_p2;
    logic [NW-1:0] r_num, r_rem;
    logic [MW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [6:0]  r_cnt;
    logic [RW-1:0] r_root;
    logic [NW+1:0] r_srem;
    logic [NW-1:0] r_sx;
    logic        r_ovalid;
    t_out_word   r_out;

    logic signed [8:0]  w_v, w_o;
    logic [NW:0]  w_trial;
    logic [NW+1:0] w_st;
    logic [RW+1:0] w_sd;
    logic [15:0]  w_win1;
    logic         w_wend;

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    assign w_v = {r_cmd.sample[7], r_cmd.sample};
    assign w_o = {r_old[7], r_old};
    assign w_win1 = (r_win == 16'hFFFF) ? r_win : r_win + 16'd1;
    assign w_wend = (w_win1 >= i_window_ms);
    assign w_trial = {r_rem, r_num[NW-1]} - {1'b0, {(NW-MW){1'b0}}, r_den};
    assign w_sd = {r_root, 2'b01};
    assign w_st = {r_srem[NW-1:0], r_sx[NW-1:NW-2]} - {{(NW-RW){1'b0}}, w_sd};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_cmd_valid) n_st = S_RD;
            S_RD:   n_st = S_RDW;
            S_RDW:  n_st = S_UPD;
            S_UPD:  n_st = (r_cmd.tick && w_wend) ? S_MUL1 : S_OUT;
            S_MUL1: n_st = S_MUL2;
            S_MUL2: n_st = S_DIFF;
            S_DIFF: n_st = (r_fill < CW'(2)) ? S_DEC : S_DIV;
            S_DIV:  if (r_cnt == 7'(NW - 1)) n_st = S_SQRT;
            S_SQRT: if (r_cnt == 7'(NW / 2 - 1)) n_st = S_DEC;
            S_DEC:  n_st = S_OUT;
            S_OUT:  if (!r_ovalid || m_out.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_RD) r_old <= r_ring[r_wi];
        if (r_st == S_UPD && r_cmd.push) begin
            if (r_fill < FULL) r_ring[AW'(r_fill)] <= r_cmd.sample;
            else r_ring[r_wi] <= r_cmd.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_wi <= '0; r_sum <= '0; r_sq <= '0;
            r_dev <= '0; r_floor <= '0; r_win <= '0; r_cal_el <= '0;
            r_hold_left <= '0; r_cal_st <= 1'b0; r_cal_done <= 1'b0;
            r_motion <= 1'b0; r_hl <= 1'b0; r_last <= 2'd2; r_ovalid <= 1'b0;
            r_rv <= 1'b0; r_rval <= 1'b0; r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd; r_rv <= 1'b0; r_rval <= 1'b0;
                end
                S_UPD: begin
                    if (r_cmd.push) begin
                        if (r_fill < FULL) begin
                            r_fill <= r_fill + CW'(1);
                            r_sum <= r_sum + SW'(w_v);
                            r_sq <= r_sq + QW'(w_v * w_v);
                        end else begin
                            r_wi <= (r_wi == AW'(RING_DEPTH - 1)) ? '0 : r_wi + AW'(1);
                            r_sum <= r_sum + SW'(w_v) - SW'(w_o);
                            r_sq <= r_sq + QW'(w_v * w_v) - QW'(w_o * w_o);
                        end
                    end
                    if (r_cmd.tick) begin
                        if (r_hold_left != 0) r_hold_left <= r_hold_left - 16'd1;
                        if (r_cal_st && !r_cal_done && r_cal_el != 16'hFFFF)
                            r_cal_el <= r_cal_el + 16'd1;
                        r_win <= w_wend ? 16'd0 : w_win1;
                    end
                    if (r_cmd.recal) begin
                        r_cal_done <= 1'b0; r_cal_st <= 1'b1; r_cal_el <= '0;
                        r_motion <= 1'b0; r_hl <= 1'b0;
                    end
                end
                S_MUL1: begin
                    r_p1 <= DW'({{(DW-CW){1'b0}}, r_fill} * DW'($unsigned(r_sq)));
                    r_p2 <= DW'($signed(r_sum) * $signed(r_sum));
                    r_den <= MW'(r_fill * r_fill);
                end
                S_MUL2: ;
                S_DIFF: begin
                    r_num <= ($signed(r_p1) < $signed(r_p2)) ? '0 :
                             {r_p1 - r_p2, 16'd0};
                    r_rem <= '0; r_cnt <= '0; r_dev <= '0;
                end
                S_DIV: begin
                    if (!w_trial[NW]) begin
                        r_rem <= w_trial[NW-1:0]; r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[NW-2:0], r_num[NW-1]};
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_num <= {r_num[NW-2:0], 1'b0};
                    r_cnt <= (r_cnt == 7'(NW - 1)) ? '0 : r_cnt + 7'd1;
                    if (r_cnt == 7'(NW - 1)) begin
                        r_sx <= w_trial[NW] ? {r_quo[NW-2:0], 1'b0}
                                            : {r_quo[NW-2:0], 1'b1};
                        r_srem <= '0; r_root <= '0;
                    end
                end
                S_SQRT: begin
                    if (!w_st[NW+1]) begin
                        r_srem <= w_st; r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_srem <= {r_srem[NW-1:0], r_sx[NW-1:NW-2]};
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                    r_sx <= {r_sx[NW-3:0], 2'b00};
                    r_cnt <= r_cnt + 7'd1;
                end
                S_DEC: begin
                    logic [14:0] dv;
                    logic        mv;
                    logic [31:0] dq;
                    dv = (r_fill < CW'(2)) ? 15'd0 :
                         (r_root > RW'(32767)) ? 15'h7FFF : r_root[14:0];
                    // ceil(dv / 10) by reciprocal multiplication
                    dq = 32'({1'b0, dv} + 16'd9) * 32'd52429;
                    r_dev <= dv;
                    if (!r_cal_done) begin
                        if (!r_cal_st) begin
                            r_cal_st <= 1'b1; r_cal_el <= '0;
                        end
                        if ((r_cal_st ? r_cal_el : 16'd0) >= i_cal_ms) begin
                            r_floor <= dv - {2'b0, dq[31:19]};
                            r_cal_done <= 1'b1;
                        end
                    end else begin
                        mv = (r_fill >= HALF) &&
                             ({2'b0, dv} > {2'b0, r_floor} + {2'b0, i_thr, 8'd0});
                        if (mv) begin
                            r_motion <= 1'b1; r_hl <= 1'b1; r_hold_left <= i_hold_ms;
                        end else if (r_hl && r_hold_left != 0) begin
                            mv = 1'b1;
                        end else begin
                            r_motion <= 1'b0; r_hl <= 1'b0;
                        end
                        if ({1'b0, mv} != r_last) begin
                            r_last <= {1'b0, mv}; r_rv <= 1'b1; r_rval <= mv;
                        end
                    end
                end
                S_OUT: if (!r_ovalid || m_out.ready) begin
                    r_ovalid <= 1'b1;
                    r_out.motion <= r_motion;
                    r_out.report_valid <= r_rv;
                    r_out.report_value <= r_rval;
                    r_out.deviation_q8 <= r_dev;
                    r_out.calibrated <= r_cal_done;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/rssi_jitter_motion_detector.sv @@
// flow: a frame, recalibrate or plain tick word goes read, read wait, update,
// output; a window-ending tick adds multiply, multiply wait, difference,
// bit-serial divide, square root (both skipped under two samples), decision
// throughput: one word at a time in the back end; a two-entry queue decouples input
// reset: synchronous active-low i_rst_n clears all control state and loads
// register defaults; ring contents stay undefined until written
//------------------------------------------------------------------------------
// rssi_jitter_motion_detector
// sliding-window rssi deviation motion detector, top level
//------------------------------------------------------------------------------
`default_nettype none
module rssi_jitter_motion_detector #(
    parameter int unsigned RING_DEPTH = rjmd_pkg::RING_DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rjmd_if.sink      s_in,
    rjmd_if.source    m_out,
    rjmd_cfg_if.sink  s_cfg
);
    import rjmd_pkg::*;

    logic [15:0] r_window, r_cal, r_hold;
    logic [6:0]  r_thr;
    t_cmd        w_cmd;
    logic        w_cmd_valid, w_pop;

    assign s_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST; r_cal <= CAL_RST;
            r_hold <= HOLD_RST; r_thr <= THR_RST;
        end else if (s_cfg.valid) begin
            case (t_reg'(s_cfg.index))
                R_WINDOW: r_window <= s_cfg.data;
                R_CAL:    r_cal <= s_cfg.data;
                R_HOLD:   r_hold <= s_cfg.data;
                R_THR:    r_thr <= s_cfg.data[6:0];
                default:  ;
            endcase
        end
    end

    rjmd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .o_cmd(w_cmd), .o_cmd_valid(w_cmd_valid), .i_cmd_pop(w_pop)
    );

    rjmd_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_cmd_valid(w_cmd_valid), .o_cmd_pop(w_pop),
        .i_window_ms(r_window), .i_cal_ms(r_cal), .i_hold_ms(r_hold),
        .i_thr(r_thr), .m_out(m_out)
    );
endmodule
`default_nettype wire
